// ===== rtl/core/slt_pkg.sv =====
// Package for the slotted leaf table: sizes, operation and status codes,
// item structs and the controller-to-datapath command struct.
// No dependencies.
`timescale 1ns / 1ps

package slt_pkg;

    // Table geometry.
    localparam int SLOTS   = 16;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int COUNT_W = $clog2(SLOTS + 1);

    // Operation codes carried in the op field of an input item.
    typedef enum logic [2:0] {
        OP_INSERT     = 3'd0,
        OP_REMOVE     = 3'd1,
        OP_FIND_KEY   = 3'd2,
        OP_FIND_VALUE = 3'd3,
        OP_READ       = 3'd4
    } slt_op_t;

    // Status codes reported with every result item.
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_EMPTY     = 2'd3
    } slt_status_t;

    // Controller states.
    typedef enum logic {
        S_IDLE   = 1'b0,
        S_FINISH = 1'b1
    } slt_state_t;

    // One input item.
    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] key;
        logic [31:0]        value;
        logic [3:0]         slot;
    } slt_in_t;

    // One result item.
    typedef struct packed {
        slt_status_t        status;
        logic [3:0]         slot_out;
        logic signed [31:0] key_out;
        logic [31:0]        value_out;
        logic [4:0]         count;
        logic               full_res;
        logic signed [31:0] min_key_out;
    } slt_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } slt_cmd_t;

endpackage

// ===== rtl/core/slotted_leaf_table.sv =====
// Top level of the slotted leaf table: joins the controller and the datapath.
// Depends on slt_pkg, slt_ctrl and slt_datapath.
`timescale 1ns / 1ps

// The slotted leaf table holds SLOTS key and value slots with valid marks and
// serves insert, remove, find by key, find by value and read, one result item
// for each input item. In the idle state an accepted item's key or value (for
// an insert, the free marks) is compared against every slot at once and the
// match vector is registered; in the finish state that vector is priority
// encoded, the chosen slot is read, the table is updated and the result is
// loaded into the output register. The finish state waits only while the
// output register still holds an earlier result that has not been taken, and
// a new item is not accepted until the last one has been finished.
module slotted_leaf_table (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  slt_pkg::slt_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output slt_pkg::slt_out_t m_data
);
    import slt_pkg::*;

    slt_cmd_t cmd;

    // Sequencer.
    slt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Table storage and match logic.
    slt_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule

// ===== rtl/core/slt_ctrl.sv =====
// Controller for the slotted leaf table: the two-state sequencer and the
// result valid flag. Depends on slt_pkg.
`timescale 1ns / 1ps

module slt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output slt_pkg::slt_cmd_t cmd
);
    import slt_pkg::*;

    slt_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    // State and result valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands. The finish step waits only while the output
    // register still holds an item that has not been taken.
    always_comb begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        s_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/core/slt_datapath.sv =====
// Datapath for the slotted leaf table: slot storage, valid marks, count,
// minimum key, the parallel match and the result register. Depends on slt_pkg.
`timescale 1ns / 1ps

module slt_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  slt_pkg::slt_cmd_t cmd,
    input  slt_pkg::slt_in_t  s_data,
    output slt_pkg::slt_out_t m_data
);
    import slt_pkg::*;

    // Slot contents, written only on insert and never reported while invalid.
    logic signed [31:0] keys_mem   [SLOTS];
    logic [31:0]        values_mem [SLOTS];

    logic [SLOTS-1:0]   valid_reg, valid_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic signed [31:0] min_key_reg, min_key_next;
    logic               min_known_reg, min_known_next;

    slt_in_t            req_reg;
    logic [SLOTS-1:0]   match_reg, match_next;
    slt_out_t           out_reg, out_next;

    logic [SLOTS-1:0]   lowest_hit;
    logic [SLOT_W-1:0]  hit_idx;
    logic               any_hit;
    logic [SLOT_W-1:0]  slot_idx;
    logic               slot_in_range;
    logic               wr_en;

    // Parallel compare of the incoming item against every slot.
    always_comb begin
        match_next = '0;
        for (int i = 0; i < SLOTS; i++) begin
            case (s_data.op)
                OP_INSERT:     match_next[i] = ~valid_reg[i];
                OP_FIND_KEY:   match_next[i] = valid_reg[i] && (keys_mem[i] == s_data.key);
                OP_FIND_VALUE: match_next[i] = valid_reg[i] &&
                                               (values_mem[i] == s_data.value);
                default:       match_next[i] = 1'b0;
            endcase
        end
    end

    // Priority encode of the registered match vector: isolate the lowest set
    // bit, then fold the one-hot vector into an index.
    always_comb begin
        lowest_hit = match_reg & (~match_reg + 1'b1);
        any_hit    = |match_reg;
        hit_idx    = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (lowest_hit[i]) begin
                hit_idx = hit_idx | SLOT_W'(i);
            end
        end
    end

    assign slot_idx      = SLOT_W'(req_reg.slot);
    assign slot_in_range = (32'(req_reg.slot) < 32'(SLOTS));

    // Operation decode: next table state and the result item.
    always_comb begin
        valid_next     = valid_reg;
        count_next     = count_reg;
        min_key_next   = min_key_reg;
        min_known_next = min_known_reg;
        wr_en          = 1'b0;

        out_next.status    = STAT_OK;
        out_next.slot_out  = '0;
        out_next.key_out   = '0;
        out_next.value_out = '0;

        unique case (req_reg.op) inside
            OP_INSERT: begin
                if (any_hit) begin
                    wr_en               = 1'b1;
                    valid_next[hit_idx] = 1'b1;
                    count_next          = count_reg + 1'b1;
                    if (!min_known_reg || (req_reg.key < min_key_reg)) begin
                        min_key_next   = req_reg.key;
                        min_known_next = 1'b1;
                    end
                    out_next.slot_out  = 4'(hit_idx);
                    out_next.key_out   = req_reg.key;
                    out_next.value_out = req_reg.value;
                end else begin
                    out_next.status = STAT_FULL;
                end
            end
            OP_REMOVE: begin
                out_next.slot_out = req_reg.slot;
                if (slot_in_range && valid_reg[slot_idx]) begin
                    valid_next[slot_idx] = 1'b0;
                    count_next           = count_reg - 1'b1;
                end else begin
                    out_next.status = STAT_EMPTY;
                end
            end
            OP_FIND_KEY, OP_FIND_VALUE: begin
                if (any_hit) begin
                    out_next.slot_out  = 4'(hit_idx);
                    out_next.key_out   = keys_mem[hit_idx];
                    out_next.value_out = values_mem[hit_idx];
                end else begin
                    out_next.status = STAT_NOT_FOUND;
                end
            end
            OP_READ: begin
                out_next.slot_out = req_reg.slot;
                if (slot_in_range && valid_reg[slot_idx]) begin
                    out_next.key_out   = keys_mem[slot_idx];
                    out_next.value_out = values_mem[slot_idx];
                end else begin
                    out_next.status = STAT_EMPTY;
                end
            end
            default: begin
                // Unused codes leave the table alone and report an OK status with zero slot, key and value.
            end
        endcase

        out_next.count       = 5'(count_next);
        out_next.full_res    = (32'(count_next) == 32'(SLOTS));
        out_next.min_key_out = min_key_next;
    end

    // Table control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            count_reg     <= '0;
            min_key_reg   <= '0;
            min_known_reg <= 1'b0;
        end else if (cmd.commit) begin
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            min_key_reg   <= min_key_next;
            min_known_reg <= min_known_next;
        end
    end

    // Slot storage write on a successful insert.
    always_ff @(posedge aclk) begin
        if (cmd.commit && wr_en) begin
            keys_mem[hit_idx]   <= req_reg.key;
            values_mem[hit_idx] <= req_reg.value;
        end
    end

    // Request, match vector and result registers.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg   <= s_data;
            match_reg <= match_next;
        end
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

// ===== test/tb_slotted_leaf_table.sv =====
// Testbench for slotted_leaf_table: directed and random table operations with
// a self-checking scoreboard that mirrors the slot table.
// Depends on slt_pkg and the slotted_leaf_table RTL.
`timescale 1ns / 1ps

module tb_slotted_leaf_table;
    import slt_pkg::*;

    // Op codes the block treats as no operation.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_POINT  = 500;
    localparam int HOLD_START   = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 200000;

    // Mirror of the slot table that predicts each result item.
    class leaf_table_model;
        logic signed [31:0] keys[SLOTS];
        logic [31:0]        vals[SLOTS];
        bit                 used[SLOTS];
        int                 fill;
        logic signed [31:0] low_key;
        bit                 low_known;
        slt_out_t           pending_results[$];
        int                 errors;
        int                 accepted;

        function new();
            foreach (used[i]) used[i] = 0;
            fill      = 0;
            low_key   = '0;
            low_known = 0;
            errors    = 0;
            accepted  = 0;
        endfunction

        // Returns a random occupied slot, or -1 when the table is empty.
        function int random_used_slot();
            int list[$];
            for (int i = 0; i < SLOTS; i++) begin
                if (used[i]) list.push_back(i);
            end
            if (list.size() == 0) return -1;
            return list[$urandom_range(0, list.size() - 1)];
        endfunction

        // Updates the mirror for one accepted request and queues its result.
        function void apply_request(slt_in_t req);
            slt_out_t r;
            int       pick;
            r = '0;
            r.status = STAT_OK;
            pick = -1;
            accepted++;
            case (req.op) inside
                OP_INSERT: begin
                    for (int i = 0; i < SLOTS && pick < 0; i++) begin
                        if (!used[i]) pick = i;
                    end
                    if (pick < 0) begin
                        r.status = STAT_FULL;
                    end else begin
                        keys[pick] = req.key;
                        vals[pick] = req.value;
                        used[pick] = 1;
                        fill++;
                        // The first insert sets the minimum; later ones only lower it.
                        if (!low_known || $signed(req.key) < $signed(low_key)) begin
                            low_key   = req.key;
                            low_known = 1;
                        end
                        r.slot_out  = pick[3:0];
                        r.key_out   = req.key;
                        r.value_out = req.value;
                    end
                end
                OP_REMOVE: begin
                    r.slot_out = req.slot;
                    if (int'(req.slot) < SLOTS && used[req.slot]) begin
                        used[req.slot] = 0;
                        fill--;
                    end else begin
                        r.status = STAT_EMPTY;
                    end
                end
                OP_FIND_KEY, OP_FIND_VALUE: begin
                    for (int i = 0; i < SLOTS && pick < 0; i++) begin
                        if (used[i] && ((req.op == OP_FIND_KEY) ? keys[i] == req.key
                                                               : vals[i] == req.value))
                            pick = i;
                    end
                    if (pick < 0) begin
                        r.status = STAT_NOT_FOUND;
                    end else begin
                        r.slot_out  = pick[3:0];
                        r.key_out   = keys[pick];
                        r.value_out = vals[pick];
                    end
                end
                OP_READ: begin
                    r.slot_out = req.slot;
                    if (int'(req.slot) < SLOTS && used[req.slot]) begin
                        r.key_out   = keys[req.slot];
                        r.value_out = vals[req.slot];
                    end else begin
                        r.status = STAT_EMPTY;
                    end
                end
                default: begin
                end
            endcase
            r.count       = fill[4:0];
            r.full_res    = (fill == SLOTS);
            r.min_key_out = low_key;
            pending_results.push_back(r);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %h got %h", $time, name, want, got);
            end
        endfunction

        // Checks one accepted result item against the oldest prediction.
        function void check_response(slt_out_t got);
            slt_out_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none got %h", $time, got);
                return;
            end
            want = pending_results.pop_front();
            compare("status", 32'(want.status), 32'(got.status));
            compare("slot_out", 32'(want.slot_out), 32'(got.slot_out));
            compare("key_out", want.key_out, got.key_out);
            compare("value_out", want.value_out, got.value_out);
            compare("count", 32'(want.count), 32'(got.count));
            compare("full_res", 32'(want.full_res), 32'(got.full_res));
            compare("min_key_out", want.min_key_out, got.min_key_out);
        endfunction
    endclass

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    slt_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    slt_out_t m_data;

    leaf_table_model sb = new();

    slotted_leaf_table uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watch both channels and feed the scoreboard on every handshake.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.apply_request(s_data);
            if (m_valid && m_ready) sb.check_response(m_data);
        end
    end

    function automatic slt_in_t make_item(logic [2:0] op, logic [31:0] key,
                                          logic [31:0] value, logic [3:0] slot);
        slt_in_t it;
        it.op    = op;
        it.key   = key;
        it.value = value;
        it.slot  = slot;
        return it;
    endfunction

    // Random request; insert-heavy and remove-heavy phases alternate so the
    // table swings between empty and full.
    function automatic slt_in_t random_request(int idx);
        slt_in_t     it;
        int          roll;
        int          ins_w;
        int          rem_w;
        int          s;
        logic [31:0] key_pool[4];
        logic [31:0] value_pool[4];
        key_pool   = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        value_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000};
        it.key   = $urandom;
        it.value = $urandom;
        it.slot  = 4'($urandom_range(0, 15));
        ins_w = ((idx / 100) % 2 == 0) ? 45 : 15;
        rem_w = 60 - ins_w;
        roll  = $urandom_range(0, 99);
        s     = sb.random_used_slot();
        if (roll < ins_w) begin
            it.op = OP_INSERT;
            // Repeated keys and values make duplicate matches common.
            if ($urandom_range(0, 2) == 0) it.key = key_pool[$urandom_range(0, 3)];
            if ($urandom_range(0, 2) == 0) it.value = value_pool[$urandom_range(0, 3)];
        end else if (roll < ins_w + rem_w) begin
            it.op = OP_REMOVE;
            if (s >= 0 && $urandom_range(0, 3) != 0) it.slot = s[3:0];
        end else if (roll < 72) begin
            it.op = OP_FIND_KEY;
            if (s >= 0 && $urandom_range(0, 3) != 0) it.key = sb.keys[s];
        end else if (roll < 84) begin
            it.op = OP_FIND_VALUE;
            if (s >= 0 && $urandom_range(0, 3) != 0) it.value = sb.vals[s];
        end else if (roll < 94) begin
            it.op = OP_READ;
            if (s >= 0 && $urandom_range(0, 3) != 0) it.slot = s[3:0];
        end else begin
            it.op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        end
        return it;
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_item(slt_in_t it);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Result side: stall patterns of its own, plus one long hold-off that
    // backs the block up while the sender keeps offering items.
    initial begin : receiver
        int mode;
        int span;
        bit held;
        m_ready = 1'b0;
        held = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 60);
            if (!held && sb.accepted >= HOLD_START) begin
                held = 1;
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                repeat (span) begin
                    @(negedge aclk);
                    case (mode)
                        0: m_ready <= 1'b1;
                        1: m_ready <= 1'($urandom_range(0, 1));
                        2: m_ready <= ($urandom_range(0, 3) == 0);
                        default: m_ready <= ~m_ready;
                    endcase
                end
            end
        end
    end

    // Stop a hung run.
    initial begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("slotted_leaf_table: mismatch");
        $finish;
    end

    // Reset, directed items, then random bursts.
    initial begin : stimulus
        int sent;
        int burst;
        bit paused;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        sent    = 0;
        paused  = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty table: reads, removes and finds all miss; spare codes do nothing.
        send_item(make_item(OP_READ, 32'h0, 32'h0, 4'd0));
        send_item(make_item(OP_REMOVE, 32'h0, 32'h0, 4'd15));
        send_item(make_item(OP_FIND_KEY, 32'h0, 32'h0, 4'd0));
        send_item(make_item(OP_FIND_VALUE, 32'h0, 32'h0, 4'd0));
        send_item(make_item(OP_SPARE_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15));
        send_item(make_item(OP_SPARE_LAST, 32'h0, 32'h0, 4'd0));

        // Fill every slot. The first key sets the minimum above zero, then the
        // extreme keys and values follow.
        send_item(make_item(OP_INSERT, 32'd100, 32'd7, 4'd0));
        send_item(make_item(OP_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 4'd0));
        send_item(make_item(OP_INSERT, 32'h8000_0000, 32'h0, 4'd0));
        send_item(make_item(OP_INSERT, 32'hFFFF_FFFF, 32'h0, 4'd0));
        for (int i = 4; i < SLOTS; i++) begin
            send_item(make_item(OP_INSERT, 32'(i * 3 - 20), 32'(i), 4'(i)));
        end

        // Full table rejects an insert; duplicates resolve to the lowest slot.
        send_item(make_item(OP_INSERT, 32'h1234_5678, 32'h9ABC_DEF0, 4'd0));
        send_item(make_item(OP_FIND_KEY, 32'hFFFF_FFFF, 32'h0, 4'd0));
        send_item(make_item(OP_FIND_VALUE, 32'h0, 32'h0, 4'd0));
        send_item(make_item(OP_READ, 32'h0, 32'h0, 4'd15));
        send_item(make_item(OP_REMOVE, 32'h0, 32'h0, 4'd15));
        send_item(make_item(OP_READ, 32'h0, 32'h0, 4'd15));
        send_item(make_item(OP_INSERT, 32'h7FFF_FFFF, 32'h5555_AAAA, 4'd0));

        // Random bursts with random gaps; once, wait for all pending results to drain.
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
                send_item(random_request(sent));
                sent++;
            end
            if (!paused && sent >= DRAIN_POINT) begin
                paused = 1;
                release_input();
                while (sb.pending_results.size() != 0) @(posedge aclk);
            end else if ($urandom_range(0, 2) != 0) begin
                release_input();
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
        release_input();

        // Wait for the last results, then keep watching for any stray item.
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("slotted_leaf_table: match");
        end else begin
            $display("slotted_leaf_table: mismatch");
        end
        $finish;
    end

endmodule
